FILE: rtl/rfp_pkg.sv
// Shared types and constants of the ranging frame parser.
`timescale 1ns / 1ps
`default_nettype none

package rfp_pkg;

	// Frame geometry
	localparam int unsigned FRAME_BYTES = 16;
	localparam int unsigned POS_W       = 4;
	localparam logic [POS_W-1:0] POS_FUNC  = 4'd1;
	localparam logic [POS_W-1:0] POS_FIRST = 4'd2;
	localparam logic [POS_W-1:0] POS_LAST  = 4'd15;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_HEADER_BYTE   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FUNCTION_CODE = 1'd1;

	// Reset values of the configuration registers
	localparam logic [7:0] HEADER_BYTE_RST   = 8'd87;
	localparam logic [7:0] FUNCTION_CODE_RST = 8'd0;

	// Output item width, padded to whole bytes
	localparam int unsigned RES_BITS  = 203;
	localparam int unsigned TDATA_OUT = 208;

	// Per-item status codes
	typedef enum logic [2:0] {
		ST_HUNT     = 3'd0,
		ST_ACCEPT   = 3'd1,
		ST_GOOD     = 3'd2,
		ST_BAD_FUNC = 3'd3,
		ST_BAD_SUM  = 3'd4
	} status_t;

	// One result item
	typedef struct packed {
		logic [31:0] checksum_error_count;
		logic [31:0] format_error_count;
		logic [31:0] good_count;
		logic [7:0]  reserved_second;
		logic [15:0] echo_strength;
		logic [7:0]  range_status;
		logic [23:0] range_mm;
		logic [31:0] sensor_time_ms;
		logic [7:0]  reserved_first;
		logic [7:0]  node_id;
		status_t     status;
	} result_t;

	// Configuration write as seen by the parser core
	typedef struct packed {
		logic                 we;
		logic [CFG_IDX_W-1:0] index;
		logic [7:0]           data;
	} cfg_wr_t;

endpackage

`default_nettype wire

FILE: rtl/rfp_core.sv
// Frame parser core: configuration registers, sync state, frame store, running checksum, latched fields, counters.
`timescale 1ns / 1ps
`default_nettype none

module rfp_core (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire rfp_pkg::cfg_wr_t cfg,
	input  wire logic            step,
	input  wire logic [7:0]      byte_in,
	output rfp_pkg::result_t     res
);

	logic [7:0] header_q;
	logic [7:0] func_q;

	logic                      synced_q;
	logic [rfp_pkg::POS_W-1:0] pos_q;
	logic [7:0]                sum_q;
	logic [7:0]                store_q [0:rfp_pkg::FRAME_BYTES-2];

	logic [7:0]  node_q, res1_q, dstat_q, res2_q;
	logic [31:0] time_q;
	logic [23:0] dist_q;
	logic [15:0] str_q;
	logic [31:0] good_q, fmt_q, chk_q;

	logic                      synced_d;
	logic [rfp_pkg::POS_W-1:0] pos_d;
	logic [7:0]                sum_d;
	logic                      wr_en;
	logic [rfp_pkg::POS_W-1:0] wr_idx;
	logic                      good_inc, fmt_inc, chk_inc;
	rfp_pkg::status_t          st;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q <= rfp_pkg::HEADER_BYTE_RST;
			func_q   <= rfp_pkg::FUNCTION_CODE_RST;
		end else if (cfg.we) begin
			unique case (cfg.index)
				rfp_pkg::REG_HEADER_BYTE:   header_q <= cfg.data;
				rfp_pkg::REG_FUNCTION_CODE: func_q   <= cfg.data;
				default: ;
			endcase
		end
	end

	// Decide the next parse state for this byte
	always_comb begin
		synced_d = synced_q;
		pos_d    = pos_q;
		sum_d    = sum_q;
		wr_en    = 1'b0;
		wr_idx   = pos_q;
		good_inc = 1'b0;
		fmt_inc  = 1'b0;
		chk_inc  = 1'b0;
		st       = rfp_pkg::ST_ACCEPT;
		if (!synced_q) begin
			// hunting: a matching byte opens a frame
			if (byte_in == header_q) begin
				synced_d = 1'b1;
				pos_d    = rfp_pkg::POS_FUNC;
				sum_d    = byte_in;
				wr_en    = 1'b1;
				wr_idx   = '0;
			end else begin
				st = rfp_pkg::ST_HUNT;
			end
		end else if (pos_q == rfp_pkg::POS_FUNC) begin
			if (byte_in != func_q) begin
				// wrong function code: resync, reusing the byte as a header if it fits
				fmt_inc = 1'b1;
				st      = rfp_pkg::ST_BAD_FUNC;
				if (byte_in == header_q) begin
					synced_d = 1'b1;
					pos_d    = rfp_pkg::POS_FUNC;
					sum_d    = byte_in;
					wr_en    = 1'b1;
					wr_idx   = '0;
				end else begin
					synced_d = 1'b0;
					pos_d    = '0;
				end
			end else begin
				wr_en = 1'b1;
				sum_d = sum_q + byte_in;
				pos_d = rfp_pkg::POS_FIRST;
			end
		end else if (pos_q == rfp_pkg::POS_LAST) begin
			// final byte: checksum first, then recheck the leading bytes
			priority if (sum_q != byte_in) begin
				chk_inc = 1'b1;
				st      = rfp_pkg::ST_BAD_SUM;
			end else if (store_q[0] != header_q || store_q[1] != func_q) begin
				fmt_inc = 1'b1;
				st      = rfp_pkg::ST_BAD_FUNC;
			end else begin
				good_inc = 1'b1;
				st       = rfp_pkg::ST_GOOD;
			end
			synced_d = 1'b0;
			pos_d    = '0;
		end else if (pos_q >= rfp_pkg::POS_FIRST) begin
			// frame body: store and add
			wr_en = 1'b1;
			sum_d = sum_q + byte_in;
			pos_d = pos_q + 4'd1;
		end else begin
			// synced at position zero cannot arise; drop back to hunting
			synced_d = 1'b0;
			pos_d    = '0;
			st       = rfp_pkg::ST_HUNT;
		end
	end

	// Assemble the result item from the values after this byte
	always_comb begin
		res.status               = st;
		res.node_id              = good_inc ? store_q[3] : node_q;
		res.reserved_first       = good_inc ? store_q[2] : res1_q;
		res.sensor_time_ms       = good_inc ? {store_q[7], store_q[6], store_q[5], store_q[4]}
		                                    : time_q;
		res.range_mm             = good_inc ? {store_q[10], store_q[9], store_q[8]} : dist_q;
		res.range_status         = good_inc ? store_q[11] : dstat_q;
		res.echo_strength        = good_inc ? {store_q[13], store_q[12]} : str_q;
		res.reserved_second      = good_inc ? store_q[14] : res2_q;
		res.good_count           = good_q + {31'd0, good_inc};
		res.format_error_count   = fmt_q + {31'd0, fmt_inc};
		res.checksum_error_count = chk_q + {31'd0, chk_inc};
	end

	// Advance parse state, latched fields and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			synced_q <= 1'b0;
			pos_q    <= '0;
			sum_q    <= '0;
			node_q   <= '0;
			res1_q   <= '0;
			time_q   <= '0;
			dist_q   <= '0;
			dstat_q  <= '0;
			str_q    <= '0;
			res2_q   <= '0;
			good_q   <= '0;
			fmt_q    <= '0;
			chk_q    <= '0;
		end else if (step) begin
			synced_q <= synced_d;
			pos_q    <= pos_d;
			sum_q    <= sum_d;
			node_q   <= res.node_id;
			res1_q   <= res.reserved_first;
			time_q   <= res.sensor_time_ms;
			dist_q   <= res.range_mm;
			dstat_q  <= res.range_status;
			str_q    <= res.echo_strength;
			res2_q   <= res.reserved_second;
			good_q   <= res.good_count;
			fmt_q    <= res.format_error_count;
			chk_q    <= res.checksum_error_count;
		end
	end

	// Frame store: undefined until written, so no reset
	always_ff @(posedge clk) begin
		if (step && wr_en) begin
			store_q[wr_idx] <= byte_in;
		end
	end

	a_pos_tracks_sync: assert property (@(posedge clk) disable iff (!arst_n)
		synced_q == (pos_q != '0))
		else $error("byte position disagrees with sync state");

	a_counters_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> $stable(good_q) && $stable(fmt_q) && $stable(chk_q))
		else $error("counter moved without an item");

	a_good_counts: assert property (@(posedge clk) disable iff (!arst_n)
		step && st == rfp_pkg::ST_GOOD |=> good_q == $past(good_q) + 32'd1)
		else $error("good frame not counted");

	a_hunt_no_count: assert property (@(posedge clk) disable iff (!arst_n)
		step && !synced_q |=> $stable(fmt_q) && $stable(chk_q) && $stable(good_q))
		else $error("counter moved while hunting");

endmodule

`default_nettype wire

FILE: rtl/ranging_frame_parser.sv
// Top level of the ranging frame parser: stream input register, parser core, result register.
//
// Usage: received bytes enter on the s_axis channel, one byte per item in
// s_axis_tdata. Every byte gives exactly one result item on m_axis: the
// per-byte status, the fields of the latest good frame and the three
// event counters after this byte. A frame is a header byte, the function
// code, thirteen payload bytes and a sum-of-bytes checksum.
// Configuration (header byte, function code) is written through cfg_we,
// cfg_index and cfg_data while no item is in flight.
// Path: a byte taken into the input register runs through the parser
// logic and is loaded into the result register when the core steps,
// which happens once the result register is free or being emptied.
// Throughput: one item per cycle while m_axis_tready stays high, set by
// the single parse step between the input register and the result register.
// Reset: arst_n clears the valid flags of both registers, the sync state, the
// latched fields and the counters; the header byte returns to 87, the function code to 0.
// Stall: while m_axis_tready is low and a result waits, the result register holds;
// an empty input register still takes one more byte, then s_axis_tready drops.
`timescale 1ns / 1ps
`default_nettype none

module ranging_frame_parser (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [rfp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [7:0]                     cfg_data,
	input  wire logic                           s_axis_tvalid,
	output logic                                s_axis_tready,
	input  wire logic [7:0]                     s_axis_tdata,  // byte_in[7:0]
	output logic                                m_axis_tvalid,
	input  wire logic                           m_axis_tready,
	// status[2:0], node_id[10:3], reserved_first[18:11], sensor_time_ms[50:19],
	// range_mm[74:51], range_status[82:75], echo_strength[98:83],
	// reserved_second[106:99], good_count[138:107], format_error_count[170:139],
	// checksum_error_count[202:171], zero[207:203]
	output logic [rfp_pkg::TDATA_OUT-1:0]       m_axis_tdata
);

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             advance;
	rfp_pkg::result_t res;
	rfp_pkg::result_t res_q;
	rfp_pkg::cfg_wr_t cfg;

	assign cfg.we    = cfg_we;
	assign cfg.index = cfg_index;
	assign cfg.data  = cfg_data;

	// Move the held byte on when the result register is free or being emptied
	assign advance       = valid_s1 && (!m_axis_tvalid || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	rfp_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.step    (advance),
		.byte_in (byte_s1),
		.res     (res)
	);

	// Result register: load on advance, hold while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (advance) begin
			m_axis_tvalid <= 1'b1;
		end else if (m_axis_tready) begin
			m_axis_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign m_axis_tdata = {{(rfp_pkg::TDATA_OUT - rfp_pkg::RES_BITS){1'b0}}, res_q};

endmodule

`default_nettype wire

FILE: verif/ranging_frame_parser_test.sv
// Self-checking testbench for the ranging frame parser: directed frames, random traffic, stalls.
`timescale 1ns / 1ps

module ranging_frame_parser_test;

	// Mix of byte sequences in the random traffic
	typedef enum int {
		TR_GOOD,
		TR_BAD_SUM,
		TR_BAD_FUNC,
		TR_HDR_AS_FUNC,
		TR_TRUNCATED,
		TR_NOISE
	} traffic_t;

	logic                          clk           = 1'b0;
	logic                          arst_n        = 1'b0;
	logic                          cfg_we        = 1'b0;
	logic [rfp_pkg::CFG_IDX_W-1:0] cfg_index     = rfp_pkg::REG_HEADER_BYTE;
	logic [7:0]                    cfg_data      = 8'h00;
	logic                          s_axis_tvalid = 1'b0;
	logic                          s_axis_tready;
	logic [7:0]                    s_axis_tdata  = 8'h00;  // byte_in[7:0]
	logic                          m_axis_tvalid;
	logic                          m_axis_tready = 1'b0;
	// status[2:0], node_id[10:3], reserved_first[18:11], sensor_time_ms[50:19],
	// range_mm[74:51], range_status[82:75], echo_strength[98:83],
	// reserved_second[106:99], good_count[138:107], format_error_count[170:139],
	// checksum_error_count[202:171], zero[207:203]
	logic [rfp_pkg::TDATA_OUT-1:0] m_axis_tdata;

	// Expected results, oldest first
	rfp_pkg::result_t pending_results[$];
	int      err_count     = 0;
	int      items_sent    = 0;
	int      sender_gap_pct = 20;
	int      stall_pct     = 20;
	int      hold_cycles   = 0;

	// Predictor state
	logic [7:0]  cfg_header  = rfp_pkg::HEADER_BYTE_RST;
	logic [7:0]  cfg_func    = rfp_pkg::FUNCTION_CODE_RST;
	logic        in_frame    = 1'b0;
	logic [3:0]  frame_pos   = '0;
	logic [7:0]  frame_bytes [15];
	logic [7:0]  byte_sum    = '0;
	logic [7:0]  lat_node    = '0;
	logic [7:0]  lat_res1    = '0;
	logic [31:0] lat_time    = '0;
	logic [23:0] lat_dist    = '0;
	logic [7:0]  lat_dstat   = '0;
	logic [15:0] lat_strength = '0;
	logic [7:0]  lat_res2    = '0;
	logic [31:0] cnt_good    = '0;
	logic [31:0] cnt_format  = '0;
	logic [31:0] cnt_sum     = '0;

	// Frame under construction for the sender
	logic [7:0] tx_frame [16];

	ranging_frame_parser u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Advance the parser by one byte and return the result it should give
	function automatic rfp_pkg::result_t parse_byte(input logic [7:0] b);
		rfp_pkg::result_t r;
		rfp_pkg::status_t st;
		st = rfp_pkg::ST_ACCEPT;
		if (!in_frame) begin
			if (b == cfg_header) begin
				in_frame = 1'b1;
				frame_bytes[0] = b;
				frame_pos = rfp_pkg::POS_FUNC;
				byte_sum = b;
			end else begin
				st = rfp_pkg::ST_HUNT;
			end
		end else if (frame_pos == rfp_pkg::POS_FUNC) begin
			if (b != cfg_func) begin
				cnt_format = cnt_format + 1;
				st = rfp_pkg::ST_BAD_FUNC;
				if (b == cfg_header) begin
					frame_bytes[0] = b;
					frame_pos = rfp_pkg::POS_FUNC;
					byte_sum = b;
				end else begin
					in_frame = 1'b0;
					frame_pos = '0;
				end
			end else begin
				frame_bytes[1] = b;
				byte_sum = byte_sum + b;
				frame_pos = rfp_pkg::POS_FIRST;
			end
		end else if (frame_pos >= rfp_pkg::POS_FIRST && frame_pos < rfp_pkg::POS_LAST) begin
			frame_bytes[frame_pos] = b;
			byte_sum = byte_sum + b;
			frame_pos = frame_pos + 1'b1;
		end else if (frame_pos == rfp_pkg::POS_LAST) begin
			// checksum takes priority over a stale header or function code
			if (byte_sum != b) begin
				cnt_sum = cnt_sum + 1;
				st = rfp_pkg::ST_BAD_SUM;
			end else if (frame_bytes[0] != cfg_header || frame_bytes[1] != cfg_func) begin
				cnt_format = cnt_format + 1;
				st = rfp_pkg::ST_BAD_FUNC;
			end else begin
				lat_node     = frame_bytes[3];
				lat_res1     = frame_bytes[2];
				lat_time     = {frame_bytes[7], frame_bytes[6], frame_bytes[5], frame_bytes[4]};
				lat_dist     = {frame_bytes[10], frame_bytes[9], frame_bytes[8]};
				lat_dstat    = frame_bytes[11];
				lat_strength = {frame_bytes[13], frame_bytes[12]};
				lat_res2     = frame_bytes[14];
				cnt_good     = cnt_good + 1;
				st = rfp_pkg::ST_GOOD;
			end
			in_frame = 1'b0;
			frame_pos = '0;
		end else begin
			in_frame = 1'b0;
			frame_pos = '0;
			st = rfp_pkg::ST_HUNT;
		end
		r.status               = st;
		r.node_id              = lat_node;
		r.reserved_first       = lat_res1;
		r.sensor_time_ms       = lat_time;
		r.range_mm             = lat_dist;
		r.range_status         = lat_dstat;
		r.echo_strength        = lat_strength;
		r.reserved_second      = lat_res2;
		r.good_count           = cnt_good;
		r.format_error_count   = cnt_format;
		r.checksum_error_count = cnt_sum;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			err_count++;
		end
	endtask

	// Compare each result item with the oldest expectation
	always @(posedge clk) begin
		rfp_pkg::result_t got;
		rfp_pkg::result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = rfp_pkg::result_t'(m_axis_tdata[rfp_pkg::RES_BITS-1:0]);
			if (pending_results.size() == 0) begin
				$display("%0t: result item with nothing expected, status %0d",
					$time, got.status);
				err_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("status", 32'(want.status), 32'(got.status));
				check_field("node_id", 32'(want.node_id), 32'(got.node_id));
				check_field("reserved_first", 32'(want.reserved_first),
					32'(got.reserved_first));
				check_field("sensor_time_ms", want.sensor_time_ms, got.sensor_time_ms);
				check_field("range_mm", 32'(want.range_mm), 32'(got.range_mm));
				check_field("range_status", 32'(want.range_status),
					32'(got.range_status));
				check_field("echo_strength", 32'(want.echo_strength),
					32'(got.echo_strength));
				check_field("reserved_second", 32'(want.reserved_second),
					32'(got.reserved_second));
				check_field("good_count", want.good_count, got.good_count);
				check_field("format_error_count", want.format_error_count,
					got.format_error_count);
				check_field("checksum_error_count", want.checksum_error_count,
					got.checksum_error_count);
			end
		end
	end

	// Receiver: random stalls, or a counted hold-off when one is requested
	initial forever begin
		@(negedge clk);
		if (hold_cycles > 0) begin
			m_axis_tready <= 1'b0;
			hold_cycles = hold_cycles - 1;
		end else begin
			m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// Offer one byte from a falling edge and return at the falling edge after acceptance
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(0, 99) < sender_gap_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		do @(posedge clk); while (!s_axis_tready);
		pending_results.push_back(parse_byte(b));
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_frame_bytes(input int first, input int last);
		for (int i = first; i <= last; i++)
			send_byte(tx_frame[i]);
	endtask

	// Hold the input idle until every expected result has come out
	task automatic wait_drain();
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic write_reg(input logic [rfp_pkg::CFG_IDX_W-1:0] idx,
			input logic [7:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == rfp_pkg::REG_HEADER_BYTE)
			cfg_header = val;
		else
			cfg_func = val;
		@(negedge clk);
	endtask

	task automatic set_config(input logic [7:0] hdr, input logic [7:0] func);
		wait_drain();
		write_reg(rfp_pkg::REG_HEADER_BYTE, hdr);
		write_reg(rfp_pkg::REG_FUNCTION_CODE, func);
	endtask

	function automatic logic [7:0] payload_byte();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick == 0)
			return 8'h00;
		else if (pick == 1)
			return 8'hFF;
		return 8'($urandom);
	endfunction

	// Fill tx_frame with a well-formed frame for the current registers
	task automatic build_frame();
		logic [7:0] s;
		tx_frame[0] = cfg_header;
		tx_frame[1] = cfg_func;
		for (int i = 2; i < 15; i++)
			tx_frame[i] = payload_byte();
		s = '0;
		for (int i = 0; i < 15; i++)
			s = s + tx_frame[i];
		tx_frame[15] = s;
	endtask

	function automatic logic [7:0] foreign_byte();
		logic [7:0] b;
		do b = 8'($urandom); while (b == cfg_func || b == cfg_header);
		return b;
	endfunction

	function automatic traffic_t pick_traffic();
		int p;
		p = $urandom_range(0, 99);
		if (p < 55) return TR_GOOD;
		if (p < 65) return TR_BAD_SUM;
		if (p < 73) return TR_BAD_FUNC;
		if (p < 78) return TR_HDR_AS_FUNC;
		if (p < 88) return TR_TRUNCATED;
		return TR_NOISE;
	endfunction

	// Mostly well-formed frames with random content, plus broken ones and noise
	task automatic run_traffic(input int n_bytes);
		int stop_at;
		int n;
		stop_at = items_sent + n_bytes;
		while (items_sent < stop_at) begin
			build_frame();
			case (pick_traffic())
				TR_GOOD: begin
					send_frame_bytes(0, 15);
				end
				TR_BAD_SUM: begin
					tx_frame[15] = tx_frame[15] ^ 8'($urandom_range(1, 255));
					send_frame_bytes(0, 15);
				end
				TR_BAD_FUNC: begin
					tx_frame[1] = foreign_byte();
					send_frame_bytes(0, 1);
				end
				TR_HDR_AS_FUNC: begin
					if (cfg_header != cfg_func)
						send_byte(cfg_header);
					send_frame_bytes(0, 15);
				end
				TR_TRUNCATED: begin
					send_frame_bytes(0, $urandom_range(2, 14));
				end
				default: begin
					n = $urandom_range(1, 6);
					repeat (n)
						send_byte(($urandom_range(0, 9) == 0) ? cfg_header : 8'($urandom));
				end
			endcase
			// now and then let everything drain before going on
			if ($urandom_range(0, 39) == 0)
				wait_drain();
		end
	endtask

	// Bytes other than the header are discarded while hunting
	task automatic test_hunting();
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(cfg_header - 8'd1);
		send_byte(cfg_header + 8'd1);
	endtask

	// One good frame with every payload byte at its maximum, so the sum wraps
	task automatic test_good_frame();
		build_frame();
		for (int i = 2; i < 15; i++)
			tx_frame[i] = 8'hFF;
		tx_frame[15] = '0;
		for (int i = 0; i < 15; i++)
			tx_frame[15] = tx_frame[15] + tx_frame[i];
		send_frame_bytes(0, 15);
	endtask

	// Wrong function code: resume hunting, or restart when it is a header byte
	task automatic test_bad_function();
		send_byte(cfg_header);
		send_byte(foreign_byte());
		send_byte(cfg_header);
		send_byte(cfg_header);
		send_byte(foreign_byte());
	endtask

	// Rewrite the registers while a frame is half received
	task automatic test_rewrite_mid_frame();
		// function code changes: good checksum still gives a format error
		build_frame();
		send_frame_bytes(0, 7);
		wait_drain();
		write_reg(rfp_pkg::REG_FUNCTION_CODE, 8'hFF);
		send_frame_bytes(8, 15);
		// header changes and the checksum is also wrong: checksum error wins
		build_frame();
		tx_frame[15] = tx_frame[15] ^ 8'h80;
		send_frame_bytes(0, 7);
		wait_drain();
		write_reg(rfp_pkg::REG_HEADER_BYTE, 8'h00);
		send_frame_bytes(8, 15);
	endtask

	task automatic test_config_sweep();
		logic [7:0] h;
		set_config(8'h00, 8'hFF);
		run_traffic(150);
		set_config(8'hFF, 8'h00);
		run_traffic(150);
		set_config(8'($urandom), 8'($urandom));
		run_traffic(110);
		// header and function code equal
		h = 8'($urandom);
		set_config(h, h);
		run_traffic(100);
		set_config(rfp_pkg::HEADER_BYTE_RST, rfp_pkg::FUNCTION_CODE_RST);
		run_traffic(80);
	endtask

	// Hold the output off long enough for the input to stall
	task automatic test_backpressure();
		wait_drain();
		sender_gap_pct = 0;
		hold_cycles = 60;
		run_traffic(50);
		wait_drain();
		sender_gap_pct = 20;
	endtask

	// Long stretch with no idling on either side
	task automatic test_streaming();
		wait_drain();
		sender_gap_pct = 0;
		stall_pct = 0;
		run_traffic(150);
		wait_drain();
		sender_gap_pct = 20;
		stall_pct = 20;
	endtask

	initial begin
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_hunting();
		test_good_frame();
		test_bad_function();
		test_rewrite_mid_frame();
		test_config_sweep();
		test_backpressure();
		test_streaming();
		wait_drain();
		repeat (5) @(negedge clk);
		if (err_count == 0)
			$display("ranging_frame_parser_test: done, clean");
		else
			$display("ranging_frame_parser_test: done, errors");
		$finish;
	end

	// Stop a hung run
	initial begin
		#2000000;
		$display("ranging_frame_parser_test: done, errors");
		$finish;
	end

endmodule
